FILE: design/sensor_sample_median_filter_assert.svh
// Assertion macros for the sensor sample median filter.
// Used by the top level; no other dependencies.
`ifndef SENSOR_SAMPLE_MEDIAN_FILTER_ASSERT_SVH
`define SENSOR_SAMPLE_MEDIAN_FILTER_ASSERT_SVH

// same-cycle implication
`define SMF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smf assertion failed");

// next-cycle implication
`define SMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smf assertion failed");

`endif

FILE: design/smf_pkg.sv
// Shared constants and controller/datapath interface types for the median filter.
// No dependencies.
`timescale 1ns / 1ps

package smf_pkg;

	localparam int SMF_AW            = 10;
	localparam int SMF_BLOCK_SAMPLES = 9;

	typedef struct packed {
		logic insert;
		logic pick;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
	} dp_sts_t;

endpackage

FILE: design/smf_ctrl.sv
// Controller for the median filter: input acceptance, median pick, output valid.
// Depends on smf_pkg.
`timescale 1ns / 1ps

module smf_ctrl import smf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [1:0] {
		S_LOAD = 2'b01,
		S_PICK = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready   = (state_q == S_LOAD);
	assign cmd.insert = in_valid && in_ready;
	assign cmd.pick   = (state_q == S_PICK) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				if (cmd.insert && sts.last) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				if (cmd.pick) begin
					state_d = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.pick) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/smf_dp.sv
// Datapath for the median filter: insertion-sorted cell row, one-count, output registers.
// Depends on smf_pkg.
`timescale 1ns / 1ps

module smf_dp import smf_pkg::*; #(
	parameter int BLOCK_SAMPLES = SMF_BLOCK_SAMPLES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic [SMF_AW-1:0] analog_sample,
	input  logic              digital_sample,
	output logic [SMF_AW-1:0] median_analog,
	output logic              median_digital
);

	localparam int CW  = $clog2(BLOCK_SAMPLES + 1);
	localparam int MID = (BLOCK_SAMPLES - 1) / 2;

	logic [SMF_AW-1:0]        cell_q [BLOCK_SAMPLES];
	logic [SMF_AW-1:0]        cell_d [BLOCK_SAMPLES];
	logic [BLOCK_SAMPLES-1:0] gt;
	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            ones_q;

	for (genvar k = 0; k < BLOCK_SAMPLES; k++) begin : g_cell
		assign gt[k] = (CW'(k) >= cnt_q) || (cell_q[k] > analog_sample);

		if (k == 0) begin : g_head
			assign cell_d[k] = gt[k] ? analog_sample : cell_q[k];
		end else begin : g_body
			assign cell_d[k] = !gt[k]   ? cell_q[k]     :
			                   !gt[k-1] ? analog_sample : cell_q[k-1];
		end

		always_ff @(posedge clk) begin
			if (cmd.insert) begin
				cell_q[k] <= cell_d[k];
			end
		end
	end

	assign sts.last = (cnt_q == CW'(BLOCK_SAMPLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ones_q <= '0;
		end else if (cmd.pick) begin
			cnt_q  <= '0;
			ones_q <= '0;
		end else if (cmd.insert) begin
			cnt_q  <= cnt_q + CW'(1);
			ones_q <= ones_q + CW'(digital_sample);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			median_analog  <= cell_q[MID];
			median_digital <= (ones_q >= CW'(BLOCK_SAMPLES - MID));
		end
	end

endmodule

FILE: design/sensor_sample_median_filter.sv
// Top level of the sensor sample median filter: controller plus datapath.
// Depends on smf_pkg, smf_ctrl, smf_dp and sensor_sample_median_filter_assert.svh.
//
//  channel  | handshake             | word
//  ---------+-----------------------+-----------------------------------
//  input    | in_valid / in_ready   | analog_sample, digital_sample
//  output   | out_valid / out_ready | median_analog, median_digital
//
// One input word per cycle: each word is inserted into a sorted cell row on acceptance.
// After the last word of a block, a pick state follows in which the median is picked into the output register.
// That pick waits while the previous median is still unread; input stalls during it.
// Reset clears the sample count and the output valid; sample cells need no reset.
`timescale 1ns / 1ps
`include "sensor_sample_median_filter_assert.svh"

module sensor_sample_median_filter import smf_pkg::*; #(
	parameter int BLOCK_SAMPLES = SMF_BLOCK_SAMPLES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SMF_AW-1:0] analog_sample,
	input  logic              digital_sample,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SMF_AW-1:0] median_analog,
	output logic              median_digital
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	smf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	smf_dp #(
		.BLOCK_SAMPLES (BLOCK_SAMPLES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.analog_sample  (analog_sample),
		.digital_sample (digital_sample),
		.median_analog  (median_analog),
		.median_digital (median_digital)
	);

	`SMF_ASSERT_NEXT(a_last_stalls, clk, arst_n, cmd.insert && sts.last, !in_ready)
	`SMF_ASSERT_NEXT(a_pick_valid, clk, arst_n, cmd.pick, out_valid)
	`SMF_ASSERT_NOW(a_pick_excl, clk, arst_n, cmd.pick, !cmd.insert)

endmodule

FILE: bench/tb_sensor_sample_median_filter.sv
// Testbench for the sensor sample median filter: a queued word driver, a median
// predictor and a checking monitor on the result channel.
// Depends on smf_pkg and the sensor_sample_median_filter design.
`timescale 1ns / 1ps

module tb_sensor_sample_median_filter import smf_pkg::*; ();

	localparam int DIRECTED_WORDS = 25;
	localparam int RANDOM_WORDS   = 1406;
	localparam int TOTAL_WORDS    = DIRECTED_WORDS + RANDOM_WORDS;
	localparam int PHASE_WORDS    = RANDOM_WORDS / 3;
	localparam int QUIET_START    = DIRECTED_WORDS + 2 * PHASE_WORDS;
	localparam int HOLD_CYCLES    = 300;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int MID            = (SMF_BLOCK_SAMPLES - 1) / 2;
	localparam logic [SMF_AW-1:0] ANALOG_MAX = '1;

	typedef logic [SMF_AW-1:0] sample_row_t [SMF_BLOCK_SAMPLES];

	typedef struct packed {
		logic [SMF_AW-1:0] analog;
		logic              digital;
	} sample_pair_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [SMF_AW-1:0] analog_sample = '0;
	logic              digital_sample = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [SMF_AW-1:0] median_analog;
	logic              median_digital;

	sample_pair_t pending_words[$];
	sample_pair_t median_queue[$];
	sample_pair_t next_word;
	sample_pair_t due;

	sample_row_t analog_row;
	sample_row_t digital_row;
	int          fill_level = 0;

	int word_count = 0;
	int medians_checked = 0;
	int error_count = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	sensor_sample_median_filter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.analog_sample (analog_sample),
		.digital_sample(digital_sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.median_analog (median_analog),
		.median_digital(median_digital)
	);

	always #10 clk = ~clk;

	function automatic logic [SMF_AW-1:0] middle_value(sample_row_t row);
		logic [SMF_AW-1:0] key;
		int i;
		int j;
		for (i = 1; i < SMF_BLOCK_SAMPLES; i++) begin
			key = row[i];
			j = i - 1;
			while (j >= 0 && row[j] > key) begin
				row[j + 1] = row[j];
				j--;
			end
			row[j + 1] = key;
		end
		return row[MID];
	endfunction

	function automatic void absorb_sample(logic [SMF_AW-1:0] a, logic d);
		logic [SMF_AW-1:0] a_mid;
		logic [SMF_AW-1:0] d_mid;
		analog_row[fill_level] = a;
		digital_row[fill_level] = {{(SMF_AW - 1){1'b0}}, d};
		fill_level++;
		if (fill_level == SMF_BLOCK_SAMPLES) begin
			a_mid = middle_value(analog_row);
			d_mid = middle_value(digital_row);
			median_queue.push_back('{analog: a_mid, digital: d_mid[0]});
			fill_level = 0;
		end
	endfunction

	function automatic int send_idle_pct(int words);
		if (words < DIRECTED_WORDS + PHASE_WORDS)
			return 35;
		else if (words < QUIET_START)
			return 61;
		return 0;
	endfunction

	function automatic int recv_idle_pct(int words);
		if (words < DIRECTED_WORDS + PHASE_WORDS)
			return 61;
		else if (words < QUIET_START)
			return 35;
		return 0;
	endfunction

	function automatic logic [SMF_AW-1:0] random_analog();
		case ($urandom_range(7))
			0: return '0;
			1: return ANALOG_MAX;
			2, 3: return SMF_AW'(500 + $urandom_range(12));
			default: return SMF_AW'($urandom_range(int'(ANALOG_MAX)));
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			analog_sample <= '0;
			digital_sample <= 1'b0;
			word_count <= 0;
		end else begin
			if (in_valid && in_ready) begin
				absorb_sample(analog_sample, digital_sample);
				word_count <= word_count + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0
						&& $urandom_range(99) >= send_idle_pct(word_count)) begin
					next_word = pending_words.pop_front();
					analog_sample <= next_word.analog;
					digital_sample <= next_word.digital;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (median_queue.size() == 0) begin
					$error("median word with none expected: analog %0d digital %0d",
						median_analog, median_digital);
					error_count++;
				end else begin
					due = median_queue.pop_front();
					medians_checked++;
					if (median_analog !== due.analog) begin
						$error("median_analog: expected %0d, got %0d", due.analog, median_analog);
						error_count++;
					end
					if (median_digital !== due.digital) begin
						$error("median_digital: expected %0d, got %0d",
							due.digital, median_digital);
						error_count++;
					end
				end
			end
			// hold off once for a long stretch so the filter backs up
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && word_count >= QUIET_START) begin
				out_ready <= 1'b0;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct(word_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int i;
		for (i = 0; i < SMF_BLOCK_SAMPLES; i++)
			pending_words.push_back('{analog: '0, digital: 1'b0});
		for (i = 0; i < SMF_BLOCK_SAMPLES; i++)
			pending_words.push_back('{analog: ANALOG_MAX, digital: 1'b1});
		for (i = 0; i < DIRECTED_WORDS - 2 * SMF_BLOCK_SAMPLES; i++)
			pending_words.push_back('{analog: ANALOG_MAX >> i, digital: i[0]});
		for (i = 0; i < RANDOM_WORDS; i++)
			pending_words.push_back('{analog: random_analog(), digital: 1'($urandom_range(1))});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (word_count < TOTAL_WORDS || median_queue.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d sample words (%0d directed) under three idling mixes",
			word_count, DIRECTED_WORDS);
		$display("and one long hold-off; checked %0d block medians in %0d cycles.",
			medians_checked, cycle_count);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/smf_pkg.sv
design/smf_ctrl.sv
design/smf_dp.sv
design/sensor_sample_median_filter.sv
bench/tb_sensor_sample_median_filter.sv
